// ===== rtl/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// stok_pkg
// shared types, token kinds and character tables of the source tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

    localparam longint unsigned MAX_SOURCE_BYTES_DEF = 64'd16777216;
    localparam int QDEPTH   = 4;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // token kinds
    localparam logic [5:0] K_END    = 6'd0;
    localparam logic [5:0] K_ERROR  = 6'd1;
    localparam logic [5:0] K_INT    = 6'd2;
    localparam logic [5:0] K_FLOAT  = 6'd3;
    localparam logic [5:0] K_STRING = 6'd4;
    localparam logic [5:0] K_IDENT  = 6'd5;
    localparam logic [5:0] K_DOT    = 6'd6;
    localparam logic [5:0] K_ELLIP  = 6'd7;
    localparam logic [5:0] K_NONE   = 6'd0;
    localparam logic [5:0] K_MAX    = 6'd49;

    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       source_last;
    } stok_in_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [23:0] token_offset;
        logic [15:0] token_length;
        logic [19:0] token_line;
        logic [15:0] token_column;
        logic        token_last;
    } stok_out_t;

    // one classified byte in the queue
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       digit;
        logic       alpha;
        logic       space;
    } stok_ent_t;

    // view of the queue head seen by the back end
    typedef struct packed {
        logic [QCNT_W-1:0] cnt;
        stok_ent_t         e0;
        stok_ent_t         e1;
    } stok_qview_t;

    // operator lead characters: index into the operator tables, 4'hF none
    function automatic logic [3:0] op_index(input logic [7:0] c);
        logic [3:0] r;
        r = 4'hF;
        unique case (c)
            ":": r = 4'd0;
            "&": r = 4'd1;
            "|": r = 4'd2;
            "^": r = 4'd3;
            "!": r = 4'd4;
            "=": r = 4'd5;
            "<": r = 4'd6;
            ">": r = 4'd7;
            "+": r = 4'd8;
            "-": r = 4'd9;
            "*": r = 4'd10;
            "/": r = 4'd11;
            "%": r = 4'd12;
            default: r = 4'hF;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] op_base_kind(input logic [3:0] i);
        logic [5:0] k;
        unique case (i)
            4'd0:  k = 6'd10;
            4'd1:  k = 6'd20;
            4'd2:  k = 6'd22;
            4'd3:  k = 6'd24;
            4'd4:  k = 6'd27;
            4'd5:  k = 6'd11;
            4'd6:  k = 6'd31;
            4'd7:  k = 6'd34;
            4'd8:  k = 6'd37;
            4'd9:  k = 6'd40;
            4'd10: k = 6'd43;
            4'd11: k = 6'd46;
            4'd12: k = 6'd48;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    // kind of the two-character operator, K_NONE when c does not extend it
    function automatic logic [5:0] op_alt_kind(input logic [3:0] i, input logic [7:0] c);
        logic [5:0] k;
        k = K_NONE;
        unique case (i)
            4'd0:  if (c == "=") k = 6'd11;
            4'd1:  if (c == "&") k = 6'd21;
            4'd2:  if (c == "|") k = 6'd23;
            4'd3:  if (c == "=") k = 6'd25;
            4'd4:  if (c == "=") k = 6'd28;
            4'd5:  if (c == "=") k = 6'd29; else if (c == ">") k = 6'd30;
            4'd6:  if (c == "=") k = 6'd32; else if (c == "<") k = 6'd33;
            4'd7:  if (c == "=") k = 6'd35; else if (c == ">") k = 6'd36;
            4'd8:  if (c == "+") k = 6'd38; else if (c == "=") k = 6'd39;
            4'd9:  if (c == "-") k = 6'd41; else if (c == "=") k = 6'd42;
                   else if (c == ">") k = 6'd30;
            4'd10: if (c == "*") k = 6'd44; else if (c == "=") k = 6'd45;
            4'd11: if (c == "=") k = 6'd47;
            4'd12: if (c == "=") k = 6'd49;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // single-character punctuation, K_NONE otherwise
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            ",": k = 6'd8;
            ";": k = 6'd9;
            "(": k = 6'd12;
            ")": k = 6'd13;
            "{": k = 6'd14;
            "}": k = 6'd15;
            "[": k = 6'd16;
            "]": k = 6'd17;
            "?": k = 6'd18;
            "#": k = 6'd19;
            "~": k = 6'd26;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stok_front.sv =====
// ----------------------------------------------------------------------------
// stok_front
// accepts source bytes, classifies them and queues them for the scanner
// ----------------------------------------------------------------------------
`default_nettype none

module stok_front import stok_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire stok_in_t    s_data,
    input  wire logic [1:0]  pop,
    output stok_qview_t      qview
);

    stok_ent_t         ent_reg  [QDEPTH];
    stok_ent_t         ent_next [QDEPTH];
    logic [QCNT_W-1:0] cnt_reg, cnt_next, wr_idx;
    stok_ent_t         new_ent;
    logic              push;
    logic [7:0]        c;

    assign s_ready = (cnt_reg < QCNT_W'(QDEPTH));
    assign push    = s_valid && s_ready;

    // classify
    always_comb begin
        c               = s_data.source_byte;
        new_ent.data    = c;
        new_ent.last    = s_data.source_last;
        new_ent.digit   = (c >= "0") && (c <= "9");
        new_ent.alpha   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
        new_ent.space   = (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == CH_NL);
    end

    // shift queue, head always at entry 0
    always_comb begin
        wr_idx   = cnt_reg - QCNT_W'(pop);
        cnt_next = wr_idx + QCNT_W'(push);
        for (int i = 0; i < QDEPTH; i++) begin
            unique case (pop)
                2'd1:    ent_next[i] = (i + 1 < QDEPTH) ? ent_reg[(i + 1) % QDEPTH] : ent_reg[i];
                2'd2:    ent_next[i] = (i + 2 < QDEPTH) ? ent_reg[(i + 2) % QDEPTH] : ent_reg[i];
                default: ent_next[i] = ent_reg[i];
            endcase
            if (push && (wr_idx == QCNT_W'(i))) begin
                ent_next[i] = new_ent;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        for (int i = 0; i < QDEPTH; i++) begin
            ent_reg[i] <= ent_next[i];
        end
    end

    assign qview.cnt = cnt_reg;
    assign qview.e0  = ent_reg[0];
    assign qview.e1  = ent_reg[1];

endmodule

`default_nettype wire

// ===== rtl/stok_back.sv =====
// ----------------------------------------------------------------------------
// stok_back
// scanner state machine, position counters and token output register
// ----------------------------------------------------------------------------
`default_nettype none

module stok_back import stok_pkg::*; #(
    parameter longint unsigned MAX_SOURCE_BYTES = MAX_SOURCE_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire stok_qview_t qview,
    output logic [1:0]       pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output stok_out_t        m_data
);

    localparam logic [63:0] CAP_WIDE = 64'(MAX_SOURCE_BYTES) - 64'd1;
    localparam logic [23:0] POS_CAP  = (CAP_WIDE > 64'hFFFFFF) ? 24'hFFFFFF : CAP_WIDE[23:0];

    typedef enum logic [3:0] {
        S_IDLE, S_LCOM, S_BCOM, S_DOT, S_STR, S_STRESC, S_NINT, S_NFRAC,
        S_NEXPCHK, S_NSIGN, S_NEXPD, S_IDENT, S_OP
    } mode_t;

    typedef struct packed {
        logic [23:0] pos;
        logic [19:0] line;
        logic [15:0] col;
        logic [15:0] tcnt;
    } ctr_t;

    function automatic ctr_t adv(input ctr_t c, input logic [7:0] b);
        ctr_t r;
        r = c;
        if (c.pos < POS_CAP) r.pos = c.pos + 24'd1;
        if (b == CH_NL) begin
            if (c.line != 20'hFFFFF) r.line = c.line + 20'd1;
            r.col = 16'd1;
        end else if (c.col != 16'hFFFF) begin
            r.col = c.col + 16'd1;
        end
        if (c.tcnt != 16'hFFFF) r.tcnt = c.tcnt + 16'd1;
        return r;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [3:0]  op_reg, op_next;
    logic        float_reg, float_next;
    logic        endp_reg, endp_next;
    logic [23:0] tstart_reg, tstart_next;
    ctr_t        ctr_reg, ctr_next, c0, c1, c2;
    logic        out_valid_reg;
    stok_out_t   out_reg;

    logic        a_none, a_ok, b_need, b_ok, stall, fire, out_free;
    logic        do_emit, emit_end, begin_tok;
    logic [1:0]  ntake;
    logic [5:0]  emit_kind, sk, ak;
    logic [3:0]  oi;
    logic [7:0]  a, b;
    stok_out_t   tok;

    assign a        = qview.e0.data;
    assign b        = qview.e1.data;
    assign a_none   = endp_reg;
    assign a_ok     = !endp_reg && (qview.cnt != '0);
    assign b_need   = !qview.e0.last && (qview.cnt < QCNT_W'(2));
    assign b_ok     = !qview.e0.last && !b_need;
    assign out_free = !out_valid_reg || m_ready;
    assign oi       = op_index(a);
    assign sk       = single_kind(a);
    assign ak       = op_alt_kind(op_reg, a);

    // one scanner decision per cycle, held while bytes are missing or the output is full
    always_comb begin
        stall      = !a_none && !a_ok;
        ntake      = 2'd0;
        do_emit    = 1'b0;
        emit_end   = 1'b0;
        emit_kind  = K_ERROR;
        begin_tok  = 1'b0;
        mode_next  = mode_reg;
        op_next    = op_reg;
        float_next = float_reg;
        unique case (mode_reg)
            S_IDLE: begin
                if (a_none) begin
                    do_emit  = 1'b1;
                    emit_end = 1'b1;
                end else if (qview.e0.space) begin
                    ntake = 2'd1;
                end else if (a == "/" && b_need) begin
                    stall = 1'b1;
                end else if (a == "/" && b_ok && b == "/") begin
                    ntake = 2'd2;
                    mode_next = S_LCOM;
                end else if (a == "/" && b_ok && b == "*") begin
                    ntake = 2'd2;
                    mode_next = S_BCOM;
                end else begin
                    begin_tok  = 1'b1;
                    ntake      = 2'd1;
                    float_next = 1'b0;
                    if (a == ".") mode_next = S_DOT;
                    else if (a == "\"") mode_next = S_STR;
                    else if (qview.e0.digit) mode_next = S_NINT;
                    else if (qview.e0.alpha) mode_next = S_IDENT;
                    else if (oi != 4'hF) begin
                        mode_next = S_OP;
                        op_next   = oi;
                    end else begin
                        do_emit   = 1'b1;
                        emit_kind = (sk != K_NONE) ? sk : K_ERROR;
                    end
                end
            end
            S_LCOM: begin
                if (a_none || a == CH_NL) mode_next = S_IDLE;
                else ntake = 2'd1;
            end
            S_BCOM: begin
                if (a_none) mode_next = S_IDLE;
                else if (a == "*" && b_need) stall = 1'b1;
                else if (a == "*" && b_ok && b == "/") begin
                    ntake = 2'd2;
                    mode_next = S_IDLE;
                end else ntake = 2'd1;
            end
            S_DOT: begin
                do_emit = 1'b1;
                emit_kind = K_DOT;
                if (!a_none && a == "." && b_need) stall = 1'b1;
                else if (!a_none && a == "." && b_ok && b == ".") begin
                    ntake = 2'd2;
                    emit_kind = K_ELLIP;
                end
            end
            S_STR: begin
                if (a_none || a == CH_NL) begin
                    do_emit = 1'b1;
                    emit_kind = K_STRING;
                end else begin
                    ntake = 2'd1;
                    if (a == "\"") begin
                        do_emit = 1'b1;
                        emit_kind = K_STRING;
                    end else if (a == "\\") mode_next = S_STRESC;
                end
            end
            S_STRESC: begin
                if (!a_none) ntake = 2'd1;
                mode_next = S_STR;
            end
            S_NINT: begin
                if (!a_none && qview.e0.digit) ntake = 2'd1;
                else if (!a_none && a == "." && b_need) stall = 1'b1;
                else if (!a_none && a == "." && b_ok && qview.e1.digit) begin
                    ntake = 2'd1;
                    float_next = 1'b1;
                    mode_next = S_NFRAC;
                end else mode_next = S_NEXPCHK;
            end
            S_NFRAC: begin
                if (!a_none && qview.e0.digit) ntake = 2'd1;
                else mode_next = S_NEXPCHK;
            end
            S_NEXPCHK: begin
                if (!a_none && (a == "e" || a == "E")) begin
                    ntake = 2'd1;
                    float_next = 1'b1;
                    mode_next = S_NSIGN;
                end else begin
                    do_emit = 1'b1;
                    emit_kind = float_reg ? K_FLOAT : K_INT;
                end
            end
            S_NSIGN: begin
                if (!a_none && (a == "+" || a == "-")) ntake = 2'd1;
                mode_next = S_NEXPD;
            end
            S_NEXPD: begin
                if (!a_none && qview.e0.digit) ntake = 2'd1;
                else begin
                    do_emit = 1'b1;
                    emit_kind = K_FLOAT;
                end
            end
            S_IDENT: begin
                if (!a_none && (qview.e0.digit || qview.e0.alpha)) ntake = 2'd1;
                else begin
                    do_emit = 1'b1;
                    emit_kind = K_IDENT;
                end
            end
            S_OP: begin
                do_emit = 1'b1;
                if (!a_none && ak != K_NONE) begin
                    ntake = 2'd1;
                    emit_kind = ak;
                end else emit_kind = op_base_kind(op_reg);
            end
            default: mode_next = S_IDLE;
        endcase
        if (do_emit && !emit_end) mode_next = S_IDLE;
    end

    assign fire = !stall && (!do_emit || out_free);
    assign pop  = fire ? ntake : 2'd0;

    // counters after the bytes taken by this decision
    always_comb begin
        c0 = ctr_reg;
        if (begin_tok) c0.tcnt = 16'd0;
        c1 = adv(c0, a);
        c2 = adv(c1, b);
        unique case (ntake)
            2'd1:    ctr_next = c1;
            2'd2:    ctr_next = c2;
            default: ctr_next = c0;
        endcase
        tstart_next = begin_tok ? ctr_reg.pos : tstart_reg;
        endp_next   = endp_reg || (ntake != 2'd0 && qview.e0.last)
                      || (ntake == 2'd2 && qview.e1.last);
        if (emit_end) begin
            tok.token_kind   = K_END;
            tok.token_offset = ctr_reg.pos;
            tok.token_length = 16'd0;
            tok.token_line   = ctr_reg.line;
            tok.token_column = ctr_reg.col;
            tok.token_last   = 1'b1;
        end else begin
            tok.token_kind   = emit_kind;
            tok.token_offset = tstart_next;
            tok.token_length = ctr_next.tcnt;
            tok.token_line   = ctr_next.line;
            tok.token_column = (ctr_next.col >= ctr_next.tcnt) ?
                               ctr_next.col - ctr_next.tcnt : 16'd0;
            tok.token_last   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= S_IDLE;
            op_reg        <= '0;
            float_reg     <= 1'b0;
            endp_reg      <= 1'b0;
            tstart_reg    <= '0;
            ctr_reg       <= '{pos: 24'd0, line: 20'd1, col: 16'd1, tcnt: 16'd0};
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                if (emit_end) begin
                    mode_reg   <= S_IDLE;
                    op_reg     <= '0;
                    float_reg  <= 1'b0;
                    endp_reg   <= 1'b0;
                    tstart_reg <= '0;
                    ctr_reg    <= '{pos: 24'd0, line: 20'd1, col: 16'd1, tcnt: 16'd0};
                end else begin
                    mode_reg   <= mode_next;
                    op_reg     <= op_next;
                    float_reg  <= float_next;
                    endp_reg   <= endp_next;
                    tstart_reg <= tstart_next;
                    ctr_reg    <= ctr_next;
                end
            end
            if (fire && do_emit) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
        if (fire && do_emit) out_reg <= tok;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_tokenizer
// streaming lexer for c-like source text, one byte per input item
// ----------------------------------------------------------------------------
// Source bytes enter on the s_ channel, each with a last flag; tokens leave on
// the m_ channel as kind, offset, length, line and column, with an end token
// after the last byte. Blanks and comments are dropped. A front end classifies
// bytes into a four-entry queue; the scanner in the back end makes one
// decision per cycle, stalling while it lacks bytes or the output is full,
// and consumes zero, one or two bytes in it. Bytes inside a token or comment
// are taken one per decision; most tokens end in a separate emit decision
// that leaves the following byte queued, and a number ending without an
// exponent first passes an exponent check. The end token has its own decision.
// The queue lets input keep arriving while a token waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer import stok_pkg::*; #(
    parameter longint unsigned MAX_SOURCE_BYTES = MAX_SOURCE_BYTES_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    // source byte items
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire stok_in_t  s_data,
    // token items
    output logic           m_valid,
    input  wire logic      m_ready,
    output stok_out_t      m_data
);

    stok_qview_t qview;   // head of the byte queue
    logic [1:0]  pop;     // bytes consumed by the scanner this cycle

    // classify and queue
    stok_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .pop     (pop),
        .qview   (qview)
    );

    // scan and emit tokens
    stok_back #(
        .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .qview   (qview),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/stok_checker.sv =====
// ----------------------------------------------------------------------------
// stok_checker
// port-level checks of the source tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

module stok_checker import stok_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire stok_out_t m_data
);

    // stalled token holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("token changed while stalled");

    // end kind and last flag go together
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.token_kind == K_END) == m_data.token_last))
        else $error("end kind and last flag disagree");

    // end token has no length
    a_endlen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_last |-> m_data.token_length == 16'd0)
        else $error("end token with length");

    // real tokens have length and a line from one
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.token_last |-> m_data.token_length != 16'd0
            && m_data.token_line != 20'd0 && m_data.token_kind <= K_MAX)
        else $error("bad token fields");

endmodule

bind source_tokenizer stok_checker u_stok_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== bench/source_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_tb
// self-checking bench for the streaming source lexer
// ----------------------------------------------------------------------------
// Source bytes are pushed through the s_ channel with random gaps. A scanner
// model inside the bench tracks the lexer state and queues the tokens that
// each accepted byte should release. A monitor compares every token leaving
// the m_ channel against the oldest queued one, field by field. Directed
// sources hit literals, comments, strings and odd bytes. Random sources are
// mostly well-formed token streams with some noise mixed in.
// ----------------------------------------------------------------------------
module source_tokenizer_tb;
    import stok_pkg::*;

    // scanner states of the model
    typedef enum int {
        SM_IDLE, SM_LCOM, SM_BCOM, SM_DOT, SM_STR, SM_STRESC, SM_NINT,
        SM_NFRAC, SM_NEXPCHK, SM_NSIGN, SM_NEXPD, SM_IDENT, SM_OP
    } scan_state_t;

    localparam int PEEK_NONE = -1;
    localparam int PEEK_WAIT = -2;
    localparam int TOKENS_PER_BYTE = 4;
    localparam int N_OPS = 13;
    localparam int N_PUNCT = 11;

    // operator lead bytes, their own kind and the kinds of their extensions
    localparam string OP_LEAD = ":&|^!=<>+-*/%";
    localparam string PUNCT = ",;(){}[]?#~";
    int op_base[N_OPS] = '{10, 20, 22, 24, 27, 11, 31, 34, 37, 40, 43, 46, 48};
    string op_ext[N_OPS] = '{"=", "&", "|", "=", "=", "=>", "=<", "=>", "+=", "-=>",
                             "*=", "=", "="};
    int op_ext_kind[N_OPS][3] = '{'{11, 0, 0}, '{21, 0, 0}, '{23, 0, 0}, '{25, 0, 0},
                                  '{28, 0, 0}, '{29, 30, 0}, '{32, 33, 0}, '{35, 36, 0},
                                  '{38, 39, 0}, '{41, 42, 30}, '{44, 45, 0}, '{47, 0, 0},
                                  '{49, 0, 0}};
    int punct_kind[N_PUNCT] = '{8, 9, 12, 13, 14, 15, 16, 17, 18, 19, 26};

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    stok_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    stok_out_t m_data;

    source_tokenizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // tokens still owed by the lexer, oldest first
    stok_out_t pending_tokens[$];
    int        error_count;
    bit        steady_flow;   // when set neither side idles

    // scanner model state
    scan_state_t lex_state;
    int          lex_op;
    logic [7:0]  look[2];
    int          look_n;
    logic [23:0] tok_start;
    logic [15:0] tok_len;
    logic [23:0] byte_pos;
    logic [19:0] line_no;
    logic [15:0] col_no;
    bit          saw_float;
    bit          src_end;
    int          tokens_out;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit is_digit(int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(int c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function void lex_clear();
        lex_state = SM_IDLE;
        lex_op    = 0;
        look[0]   = '0;
        look[1]   = '0;
        look_n    = 0;
        tok_start = '0;
        tok_len   = '0;
        byte_pos  = '0;
        line_no   = 20'd1;
        col_no    = 16'd1;
        saw_float = 1'b0;
    endfunction

    function int peek(int k);
        if (k < look_n) return look[k];
        return src_end ? PEEK_NONE : PEEK_WAIT;
    endfunction

    // consume one byte and advance the position counters, all saturating
    function void consume();
        logic [7:0] c;
        if (look_n == 0) return;
        c = look[0];
        look[0] = look[1];
        look[1] = '0;
        look_n--;
        if (byte_pos != 24'hFFFFFF) byte_pos++;
        if (c == CH_NL) begin
            if (line_no != 20'hFFFFF) line_no++;
            col_no = 16'd1;
        end else if (col_no != 16'hFFFF) begin
            col_no++;
        end
        if (tok_len != 16'hFFFF) tok_len++;
    endfunction

    function void push_token(logic [5:0] kind, logic [23:0] off, logic [15:0] len,
                             logic [15:0] col, logic last);
        stok_out_t t;
        if (tokens_out >= TOKENS_PER_BYTE) return;
        t.token_kind   = kind;
        t.token_offset = off;
        t.token_length = len;
        t.token_line   = line_no;
        t.token_column = col;
        t.token_last   = last;
        pending_tokens.push_back(t);
        tokens_out++;
    endfunction

    function void close_token(int kind);
        push_token(kind[5:0], tok_start, tok_len, col_no >= tok_len ? col_no - tok_len : '0,
                   1'b0);
        lex_state = SM_IDLE;
    endfunction

    function void open_token(int a);
        tok_start = byte_pos;
        tok_len   = '0;
        saw_float = 1'b0;
        consume();
        if (a == ".") begin lex_state = SM_DOT; return; end
        if (a == "\"") begin lex_state = SM_STR; return; end
        if (is_digit(a)) begin lex_state = SM_NINT; return; end
        if (is_letter(a)) begin lex_state = SM_IDENT; return; end
        for (int i = 0; i < N_OPS; i++)
            if (OP_LEAD[i] == a) begin
                lex_state = SM_OP;
                lex_op = i;
                return;
            end
        for (int i = 0; i < N_PUNCT; i++)
            if (PUNCT[i] == a) begin
                close_token(punct_kind[i]);
                return;
            end
        close_token(K_ERROR);
    endfunction

    // one scanner decision, 0 when it needs more bytes or the source ended
    function bit lex_decide();
        int a;
        int b;
        a = peek(0);
        if (a == PEEK_WAIT) return 0;
        case (lex_state)
            SM_IDLE: begin
                if (a == PEEK_NONE) begin
                    push_token(K_END, byte_pos, '0, col_no, 1'b1);
                    lex_clear();
                    return 0;
                end
                if (a == " " || a == "\t" || a == "\r" || a == "\n") begin
                    consume();
                    return 1;
                end
                if (a == "/") begin
                    b = peek(1);
                    if (b == PEEK_WAIT) return 0;
                    if (b == "/" || b == "*") begin
                        consume();
                        consume();
                        lex_state = (b == "/") ? SM_LCOM : SM_BCOM;
                        return 1;
                    end
                end
                open_token(a);
            end
            SM_LCOM: begin
                if (a == PEEK_NONE || a == "\n") lex_state = SM_IDLE;
                else consume();
            end
            SM_BCOM: begin
                if (a == PEEK_NONE) begin
                    lex_state = SM_IDLE;
                    return 1;
                end
                if (a == "*") begin
                    b = peek(1);
                    if (b == PEEK_WAIT) return 0;
                    if (b == "/") begin
                        consume();
                        consume();
                        lex_state = SM_IDLE;
                        return 1;
                    end
                end
                consume();
            end
            SM_DOT: begin
                if (a == ".") begin
                    b = peek(1);
                    if (b == PEEK_WAIT) return 0;
                    if (b == ".") begin
                        consume();
                        consume();
                        close_token(K_ELLIP);
                        return 1;
                    end
                end
                close_token(K_DOT);
            end
            SM_STR: begin
                if (a == PEEK_NONE || a == "\n") begin
                    close_token(K_STRING);
                    return 1;
                end
                consume();
                if (a == "\"") close_token(K_STRING);
                else if (a == "\\") lex_state = SM_STRESC;
            end
            SM_STRESC: begin
                if (a != PEEK_NONE) consume();
                lex_state = SM_STR;
            end
            SM_NINT: begin
                if (is_digit(a)) begin
                    consume();
                    return 1;
                end
                if (a == ".") begin
                    b = peek(1);
                    if (b == PEEK_WAIT) return 0;
                    if (is_digit(b)) begin
                        consume();
                        saw_float = 1'b1;
                        lex_state = SM_NFRAC;
                        return 1;
                    end
                end
                lex_state = SM_NEXPCHK;
            end
            SM_NFRAC: begin
                if (is_digit(a)) consume(); else lex_state = SM_NEXPCHK;
            end
            SM_NEXPCHK: begin
                if (a == "e" || a == "E") begin
                    consume();
                    saw_float = 1'b1;
                    lex_state = SM_NSIGN;
                end else begin
                    close_token(saw_float ? K_FLOAT : K_INT);
                end
            end
            SM_NSIGN: begin
                if (a == "+" || a == "-") consume();
                lex_state = SM_NEXPD;
            end
            SM_NEXPD: begin
                if (is_digit(a)) consume(); else close_token(K_FLOAT);
            end
            SM_IDENT: begin
                if (is_digit(a) || is_letter(a)) consume(); else close_token(K_IDENT);
            end
            default: begin
                for (int j = 0; j < op_ext[lex_op].len(); j++)
                    if (a == op_ext[lex_op][j]) begin
                        consume();
                        close_token(op_ext_kind[lex_op][j]);
                        return 1;
                    end
                close_token(op_base[lex_op]);
            end
        endcase
        return 1;
    endfunction

    // queue the tokens released by one accepted byte
    function void predict_tokens(stok_in_t item);
        tokens_out = 0;
        src_end = item.source_last;
        if (look_n > 1) look_n = 1;
        look[look_n] = item.source_byte;
        look_n++;
        while (tokens_out < TOKENS_PER_BYTE && lex_decide()) begin
        end
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // token monitor
    always @(posedge aclk) begin
        stok_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d", m_data.token_kind));
            end else begin
                want = pending_tokens.pop_front();
                if (m_data.token_kind !== want.token_kind)
                    report_mismatch($sformatf("kind %0d want %0d",
                                              m_data.token_kind, want.token_kind));
                if (m_data.token_offset !== want.token_offset)
                    report_mismatch($sformatf("offset %0d want %0d",
                                              m_data.token_offset, want.token_offset));
                if (m_data.token_length !== want.token_length)
                    report_mismatch($sformatf("length %0d want %0d",
                                              m_data.token_length, want.token_length));
                if (m_data.token_line !== want.token_line)
                    report_mismatch($sformatf("line %0d want %0d",
                                              m_data.token_line, want.token_line));
                if (m_data.token_column !== want.token_column)
                    report_mismatch($sformatf("column %0d want %0d",
                                              m_data.token_column, want.token_column));
                if (m_data.token_last !== want.token_last)
                    report_mismatch($sformatf("last %0b want %0b",
                                              m_data.token_last, want.token_last));
            end
        end
    end

    // receiver back-pressure, one update per falling edge
    always @(negedge aclk) begin
        m_ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 18);
    end

    // send one byte item; valid stays up between back-to-back items
    task automatic send_byte(logic [7:0] b, logic last);
        stok_in_t item;
        item.source_byte = b;
        item.source_last = last;
        if (!steady_flow && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < 18);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predict_tokens(item);
        @(negedge aclk);
    endtask

    // send a whole source, the final byte flagged
    task automatic send_source(string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], i == text.len() - 1);
    endtask

    task automatic test_literals_and_ops();
        send_source("x_9 0 12.5 7e 3E+4 1.e ... . a->b!=c\n");
        send_source("\"s\\\"q\" \"ab\ncd ?");
    endtask

    task automatic test_comment_edges();
        send_source("// line\n/* a * b */#");
        // zero byte gives an error outside tokens, stays inside strings
        send_byte("\"", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte("\\", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
        send_source("/* open");
    endtask

    // one random fragment: mostly tokens, some noise
    function automatic string random_fragment();
        string ops[$] = '{":", ":=", "&", "&&", "|", "||", "^", "^=", "!", "!=", "=", "==",
                          "=>", "<", "<=", "<<", ">", ">=", ">>", "+", "++", "+=", "-",
                          "--", "-=", "->", "*", "**", "*=", "/", "/=", "%", "%=", ",",
                          ";", "(", ")", "{", "}", "[", "]", "?", "#", "~", ".", "..."};
        string s;
        case ($urandom_range(11))
            0: s = $sformatf("%s%0d", $urandom_range(1) ? string'("v") : string'("_W"),
                             $urandom_range(999));
            1: s = $sformatf("%0d", $urandom_range(99999));
            2: s = $sformatf("%0d.%0d", $urandom_range(99), $urandom_range(99));
            3: s = $sformatf("%0d%s%s%0d", $urandom_range(9), $urandom_range(1) ? "e" : "E",
                             $urandom_range(1) ? "-" : "+", $urandom_range(99));
            4: s = $urandom_range(1) ? string'("\"ab\\\"\\\\c\"") : string'("\"esc\\\nx\"");
            5: s = $urandom_range(1) ? string'("// note\n") : string'("/* ** / */");
            6: s = $urandom_range(1) ? string'("\n") : string'("\t \r");
            7: begin
                s = " ";
                s[0] = $urandom_range(255);
            end
            default: s = ops[$urandom_range(ops.size() - 1)];
        endcase
        return $urandom_range(2) == 0 ? s : {s, " "};
    endfunction

    task automatic test_random_sources(int n_bytes);
        string text;
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            text = "";
            repeat ($urandom_range(1, 12)) text = {text, random_fragment()};
            send_source(text);
            sent += text.len();
        end
    endtask

    // full-rate stretch with neither side idling
    task automatic test_steady_flow();
        steady_flow = 1'b1;
        test_random_sources(80);
        steady_flow = 1'b0;
    endtask

    initial begin
        error_count = 0;
        steady_flow = 1'b0;
        src_end = 1'b0;
        lex_clear();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_literals_and_ops();
        test_comment_edges();
        test_random_sources(350);
        test_steady_flow();
        test_random_sources(70);
        s_valid <= 1'b0;

        // drain, then keep waiting so the lexer can show stray tokens
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
